/* rtl/core/prwc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package prwc_pkg;

    // Field widths of the stream items.
    localparam int PID_W    = 32;
    localparam int EPOCH_W  = 32;
    localparam int TICK_W   = 32;
    localparam int STATUS_W = 2;
    localparam int BT_W     = 32;

    // Configuration register widths and reset values.
    localparam int WSIZE_W = 11;
    localparam int EXPT_W  = 31;
    localparam logic [WSIZE_W-1:0] WSIZE_RST = 11'd64;
    localparam logic [EXPT_W-1:0]  EXPT_RST  = 31'd2500;

    // Register indexes on the configuration port.
    localparam logic [0:0] REG_WINDOW_SIZE  = 1'b0;
    localparam logic [0:0] REG_EXPIRE_TICKS = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_ID    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EPOCH_BACK = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REPLAY     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                clr_sweep;
        logic                load;
        logic                eval;
        logic                path;
        logic                big_init;
        logic                big_sweep;
        logic                mod_start;
        logic                mod_sel;
        logic                cap_rbm;
        logic                fwd_set;
        logic                fclr;
        logic                baddr;
        logic                back_set;
        logic                rearm;
        logic                st_we;
        logic [STATUS_W-1:0] st_code;
        logic                emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic zero_id;
        logic epoch_old;
        logic ahead;
        logic fwd_big;
        logic back_reject;
        logic mod_done;
        logic one_step;
        logic fclr_last;
        logic big_last;
        logic bit_set;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/prwc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module prwc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/prwc_mod.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module prwc_mod #(
    parameter int AW = 10
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire [AW-1:0]  i_dividend,
    input  wire [AW:0]    i_divisor,
    output logic          o_done,
    output logic [AW-1:0] o_rem
);

    localparam int CW = $clog2(AW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [AW:0]   r_rem;
    logic [AW-1:0] r_sh;
    logic [AW:0]   trial;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    assign trial = {r_rem[AW-1:0], r_sh[AW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(AW - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_sh  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= (trial >= i_divisor) ? (trial - i_divisor) : trial;
            r_sh  <= {r_sh[AW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[AW-1:0];

endmodule

`default_nettype wire

/* rtl/core/prwc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module prwc_datapath #(
    parameter int WINDOW_MAX = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire [prwc_pkg::WSIZE_W-1:0]        i_window_size,
    input  wire [prwc_pkg::EXPT_W-1:0]         i_expire_ticks,
    input  wire [prwc_pkg::PID_W-1:0]          i_pid,
    input  wire [prwc_pkg::EPOCH_W-1:0]        i_epoch,
    input  wire [prwc_pkg::TICK_W-1:0]         i_now,
    input  prwc_pkg::t_cmd                     i_cmd,
    output prwc_pkg::t_sts                     o_sts,
    input  wire                                i_out_ready,
    output logic                               o_out_valid,
    output logic [prwc_pkg::STATUS_W-1:0]      o_status,
    output logic [prwc_pkg::BT_W-1:0]          o_backtrack
);

    localparam int AW = $clog2(WINDOW_MAX);
    localparam int WW = AW + 1;

    // Latched packet fields.
    logic [prwc_pkg::PID_W-1:0]   r_pid;
    logic [prwc_pkg::EPOCH_W-1:0] r_epoch;
    logic [prwc_pkg::TICK_W-1:0]  r_now;

    // Window state.
    logic [AW-1:0]                r_base;
    logic [WW-1:0]                r_ext;
    logic [prwc_pkg::PID_W-1:0]   r_hi;
    logic [prwc_pkg::PID_W-1:0]   r_floor;
    logic [prwc_pkg::EPOCH_W-1:0] r_cur_epoch;
    logic [prwc_pkg::TICK_W-1:0]  r_expire_at;
    logic [prwc_pkg::BT_W-1:0]    r_btmax;

    // Working registers.
    logic [AW-1:0]                r_delta;
    logic [AW-1:0]                r_rbm;
    logic [AW-1:0]                r_ri;
    logic [AW-1:0]                r_pos;
    logic [AW-1:0]                r_cnt;
    logic [prwc_pkg::STATUS_W-1:0] r_status;

    // Output register.
    logic                          r_ovalid;
    logic [prwc_pkg::STATUS_W-1:0] r_ostatus;
    logic [prwc_pkg::BT_W-1:0]     r_obt;

    logic [WW-1:0]                w;
    logic [prwc_pkg::PID_W-1:0]   w_ext;
    logic [prwc_pkg::PID_W-1:0]   ext_ext;
    logic [prwc_pkg::PID_W-1:0]   d_fwd;
    logic [prwc_pkg::PID_W-1:0]   d_back;
    logic [prwc_pkg::TICK_W-1:0]  tick_diff;
    logic                         exp_hit;
    logic                         epoch_new;
    logic                         ahead;
    logic [WW-1:0]                nb_sum;
    logic [WW-1:0]                nb_full;
    logic [AW-1:0]                nb;
    logic [WW-1:0]                nb_inc;
    logic [AW-1:0]                nb_next;
    logic [WW-1:0]                pos_inc;
    logic [AW-1:0]                pos_next;
    logic [WW:0]                  ext_sum;
    logic [WW-1:0]                ext_new;
    logic [WW-1:0]                ri_sum;
    logic [AW-1:0]                ri;
    logic                         mod_done;
    logic [AW-1:0]                mod_rem;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic                         ram_wdata;
    logic                         ram_rdata;

    // Effective window: zero acts as one, anything above the maximum is clamped.
    always_comb begin
        if (i_window_size == '0) begin
            w = WW'(1);
        end else if (32'(i_window_size) > 32'(WINDOW_MAX)) begin
            w = WW'(WINDOW_MAX);
        end else begin
            w = WW'(i_window_size);
        end
    end

    assign w_ext   = 32'(w);
    assign ext_ext = 32'(r_ext);

    // Packet classification against the current state.
    assign d_fwd     = r_pid - r_hi;
    assign d_back    = r_hi - r_pid;
    assign tick_diff = r_now - r_expire_at;
    assign exp_hit   = ~tick_diff[prwc_pkg::TICK_W-1];
    assign epoch_new = r_epoch > r_cur_epoch;
    assign ahead     = r_pid > r_hi;

    // New ring base for a short forward step, and the position after it.
    assign nb_sum  = WW'(r_rbm) + w - WW'(r_delta);
    assign nb_full = (nb_sum >= w) ? (nb_sum - w) : nb_sum;
    assign nb      = nb_full[AW-1:0];
    assign nb_inc  = WW'(nb) + WW'(1);
    assign nb_next = (nb_inc >= w) ? '0 : nb_inc[AW-1:0];
    assign pos_inc = WW'(r_pos) + WW'(1);
    assign pos_next = (pos_inc >= w) ? '0 : pos_inc[AW-1:0];

    // Valid extent grows by the step and saturates at the window.
    assign ext_sum = (WW+1)'(r_ext) + (WW+1)'(r_delta);
    assign ext_new = (ext_sum > (WW+1)'(w)) ? w : ext_sum[WW-1:0];

    // Ring index of a backtrack.
    assign ri_sum = WW'(r_rbm) + WW'(mod_rem);
    assign ri     = (ri_sum >= w) ? ri_sum[AW-1:0] - w[AW-1:0] : ri_sum[AW-1:0];

    prwc_mod #(
        .AW(AW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (i_cmd.mod_sel ? r_delta : r_base),
        .i_divisor  (w),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // Write port of the seen-bit ring.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = 1'b0;
        if (i_cmd.clr_sweep || i_cmd.fclr) begin
            ram_we = 1'b1;
        end else if (i_cmd.big_sweep) begin
            ram_we    = 1'b1;
            ram_wdata = (r_pos == '0);
        end else if (i_cmd.fwd_set) begin
            ram_we    = 1'b1;
            ram_waddr = nb;
            ram_wdata = 1'b1;
        end else if (i_cmd.back_set) begin
            ram_we    = 1'b1;
            ram_waddr = r_ri;
            ram_wdata = 1'b1;
        end
    end

    prwc_ram #(
        .WIDTH(1),
        .DEPTH(WINDOW_MAX)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ri),
        .o_rdata (ram_rdata)
    );

    // Packet fields are captured at the input beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pid   <= i_pid;
            r_epoch <= i_epoch;
            r_now   <= i_now;
        end
    end

    // Window state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_ext       <= '0;
            r_hi        <= '0;
            r_floor     <= '0;
            r_cur_epoch <= '0;
            r_expire_at <= '0;
            r_btmax     <= '0;
            r_pos       <= '0;
        end else begin
            if (i_cmd.eval) begin
                if (epoch_new) begin
                    r_base      <= '0;
                    r_ext       <= '0;
                    r_hi        <= '0;
                    r_floor     <= '0;
                    r_cur_epoch <= r_epoch;
                end else if (exp_hit) begin
                    r_floor <= r_hi;
                end
            end
            if (i_cmd.path && !ahead && (d_back > r_btmax)) begin
                r_btmax <= d_back;
            end
            if (i_cmd.big_init) begin
                r_base <= '0;
                r_ext  <= w;
                r_hi   <= r_pid;
                r_pos  <= '0;
            end
            if (i_cmd.clr_sweep || i_cmd.big_sweep) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.fwd_set) begin
                r_base <= nb;
                r_ext  <= ext_new;
                r_hi   <= r_pid;
                r_pos  <= nb_next;
            end
            if (i_cmd.fclr) begin
                r_pos <= pos_next;
            end
            if (i_cmd.rearm) begin
                r_expire_at <= r_now + 32'(i_expire_ticks);
            end
        end
    end

    // Working registers of the current packet.
    always_ff @(posedge i_clk) begin
        if (i_cmd.path) begin
            r_delta <= ahead ? d_fwd[AW-1:0] : d_back[AW-1:0];
        end
        if (i_cmd.cap_rbm) begin
            r_rbm <= mod_rem;
        end
        if (i_cmd.baddr) begin
            r_ri <= ri;
        end
        if (i_cmd.fwd_set) begin
            r_cnt <= r_delta - 1'b1;
        end else if (i_cmd.fclr) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.st_we) begin
            r_status <= i_cmd.st_code;
        end
    end

    // Output register: holds one result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ostatus <= r_status;
            r_obt     <= r_btmax;
        end
    end

    // Status toward the controller.
    assign o_sts.clr_last    = (32'(r_pos) == 32'(WINDOW_MAX - 1));
    assign o_sts.zero_id     = (r_pid == '0);
    assign o_sts.epoch_old   = (r_epoch < r_cur_epoch);
    assign o_sts.ahead       = ahead;
    assign o_sts.fwd_big     = (d_fwd >= w_ext);
    assign o_sts.back_reject = (d_back >= ext_ext) || (r_pid <= r_floor);
    assign o_sts.mod_done    = mod_done;
    assign o_sts.one_step    = (r_delta == AW'(1));
    assign o_sts.fclr_last   = (r_cnt == AW'(1));
    assign o_sts.big_last    = (WW'(r_pos) == (w - WW'(1)));
    assign o_sts.bit_set     = ram_rdata;
    assign o_sts.out_free    = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_backtrack = r_obt;

endmodule

`default_nettype wire

/* rtl/core/prwc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module prwc_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  prwc_pkg::t_sts  i_sts,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output prwc_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_PATH  = 4'd3;
    localparam logic [3:0] S_BIG   = 4'd4;
    localparam logic [3:0] S_MOD1  = 4'd5;
    localparam logic [3:0] S_FWD   = 4'd6;
    localparam logic [3:0] S_FCLR  = 4'd7;
    localparam logic [3:0] S_MOD2  = 4'd8;
    localparam logic [3:0] S_BREAD = 4'd9;
    localparam logic [3:0] S_BCHK  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencing of one packet check.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                // Clear the seen-bit ring once after reset.
                o_cmd.clr_sweep = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.zero_id) begin
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = prwc_pkg::ST_ZERO_ID;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.eval = 1'b1;
                    if (i_sts.epoch_old) begin
                        o_cmd.st_we   = 1'b1;
                        o_cmd.st_code = prwc_pkg::ST_EPOCH_BACK;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_PATH;
                    end
                end
            end
            S_PATH: begin
                o_cmd.path = 1'b1;
                if (i_sts.ahead && i_sts.fwd_big) begin
                    o_cmd.big_init = 1'b1;
                    n_state        = S_BIG;
                end else if (!i_sts.ahead && i_sts.back_reject) begin
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = prwc_pkg::ST_REPLAY;
                    n_state       = S_DONE;
                end else begin
                    // Both short steps need the ring base reduced to the window.
                    o_cmd.mod_start = 1'b1;
                    n_state         = S_MOD1;
                end
            end
            S_BIG: begin
                o_cmd.big_sweep = 1'b1;
                if (i_sts.big_last) begin
                    o_cmd.rearm   = 1'b1;
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = prwc_pkg::ST_OK;
                    n_state       = S_DONE;
                end
            end
            S_MOD1: begin
                if (i_sts.mod_done) begin
                    o_cmd.cap_rbm = 1'b1;
                    if (i_sts.ahead) begin
                        n_state = S_FWD;
                    end else begin
                        o_cmd.mod_start = 1'b1;
                        o_cmd.mod_sel   = 1'b1;
                        n_state         = S_MOD2;
                    end
                end
            end
            S_FWD: begin
                o_cmd.fwd_set = 1'b1;
                if (i_sts.one_step) begin
                    o_cmd.rearm   = 1'b1;
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = prwc_pkg::ST_OK;
                    n_state       = S_DONE;
                end else begin
                    n_state = S_FCLR;
                end
            end
            S_FCLR: begin
                // Clear the bits skipped by the forward step.
                o_cmd.fclr = 1'b1;
                if (i_sts.fclr_last) begin
                    o_cmd.rearm   = 1'b1;
                    o_cmd.st_we   = 1'b1;
                    o_cmd.st_code = prwc_pkg::ST_OK;
                    n_state       = S_DONE;
                end
            end
            S_MOD2: begin
                if (i_sts.mod_done) begin
                    o_cmd.baddr = 1'b1;
                    n_state     = S_BREAD;
                end
            end
            S_BREAD: begin
                n_state = S_BCHK;
            end
            S_BCHK: begin
                o_cmd.st_we = 1'b1;
                if (i_sts.bit_set) begin
                    o_cmd.st_code = prwc_pkg::ST_REPLAY;
                end else begin
                    o_cmd.back_set = 1'b1;
                    o_cmd.rearm    = 1'b1;
                    o_cmd.st_code  = prwc_pkg::ST_OK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/packet_replay_window_check.sv */
`timescale 1ns / 1ps
`default_nettype none

// Anti-replay window check, one result beat for each packet beat.
// Input stream s_axis carries packet id, epoch and the current tick count;
// output stream m_axis carries the status and the largest backtrack so far.
// Window size and expiry time must be written over the APB port only
// while idle; the block itself does not enforce this.
// One packet is checked at a time; it ends as a zero id, an older epoch,
// a refused backtrack, a backtrack looked up in the ring, a forward step
// below the window w or a jump of at least w. The time per packet is set
// by the bit-serial remainder unit that maps ids onto the ring and by the
// single write port of the seen-bit memory, which clears skipped positions
// one per cycle. After reset the seen-bit memory is swept clear of all
// WINDOW_MAX positions, during which s_axis_tready stays low.
// A finished result sits in an output register; the next packet is taken
// while it waits, but its own result is held back until the receiver has
// taken the earlier one.
module packet_replay_window_check #(
    parameter int WINDOW_MAX = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // APB configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Packet input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [95:0] s_axis_tdata,   // packet_id, packet_epoch, now_ticks
    // Result output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // status, largest_backtrack, zero fill
);

    logic [prwc_pkg::WSIZE_W-1:0]  r_window_size;
    logic [prwc_pkg::EXPT_W-1:0]   r_expire_ticks;
    logic                          cfg_wr;
    prwc_pkg::t_cmd                w_cmd;
    prwc_pkg::t_sts                w_sts;
    logic [prwc_pkg::STATUS_W-1:0] out_status;
    logic [prwc_pkg::BT_W-1:0]     out_bt;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size  <= prwc_pkg::WSIZE_RST;
            r_expire_ticks <= prwc_pkg::EXPT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                prwc_pkg::REG_WINDOW_SIZE: begin
                    r_window_size <= pwdata[prwc_pkg::WSIZE_W-1:0];
                end
                prwc_pkg::REG_EXPIRE_TICKS: begin
                    r_expire_ticks <= pwdata[prwc_pkg::EXPT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            prwc_pkg::REG_WINDOW_SIZE:  prdata = 32'(r_window_size);
            prwc_pkg::REG_EXPIRE_TICKS: prdata = 32'(r_expire_ticks);
            default:                    prdata = '0;
        endcase
    end

    prwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (w_sts),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    prwc_datapath #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window_size  (r_window_size),
        .i_expire_ticks (r_expire_ticks),
        .i_pid          (s_axis_tdata[31:0]),
        .i_epoch        (s_axis_tdata[63:32]),
        .i_now          (s_axis_tdata[95:64]),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_status       (out_status),
        .o_backtrack    (out_bt)
    );

    assign m_axis_tdata = {6'b0, out_bt, out_status};

`ifndef SYNTH
    // A packet is never followed by another in the very next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second packet taken while one is in work");

    // A new result only appears when the controller hands one over.
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.emit))
        else $error("result beat raised without an emit command");

    // At most one writer of the seen-bit ring in any cycle.
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clr_sweep, w_cmd.big_sweep, w_cmd.fwd_set,
                  w_cmd.fclr, w_cmd.back_set}))
        else $error("conflicting writes to the seen-bit ring");
`endif

endmodule

`default_nettype wire

/* test/replay_window_checker.sv */
`timescale 1ns / 1ps

// Watches the register port and both packet streams, predicts the verdict of
// every accepted packet beat and compares each result beat with the oldest
// prediction that is still waiting.
module replay_window_checker #(
    parameter int WIN_MAX = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    input  wire  [31:0] i_prdata,
    input  wire         i_pready,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire  [95:0] i_in_data,    // packet_id, packet_epoch, now_ticks
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [39:0] i_out_data,   // status, largest_backtrack, zero fill
    output int          o_pending,
    output int          o_fail_count
);

    import prwc_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BT_W-1:0]     backtrack;
    } verdict_t;

    // Our copy of the two configuration registers.
    logic [WSIZE_W-1:0] win_size_reg;
    logic [EXPT_W-1:0]  expire_len_reg;

    // Our copy of the replay window.
    bit          seen_map [WIN_MAX];
    int unsigned ring_base;
    int unsigned extent;
    logic [31:0] top_id;
    logic [31:0] id_floor;
    logic [31:0] cur_epoch;
    logic [31:0] expire_at;
    logic [31:0] backtrack_max;

    verdict_t verdict_q [$];
    int       fail_total = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_total++;
        if (fail_total <= 40) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Works out the status of one packet and updates the window copy.
    function automatic verdict_t judge_packet(input logic [31:0] pid,
                                              input logic [31:0] epoch,
                                              input logic [31:0] now);
        verdict_t    v;
        int unsigned w;
        int unsigned pos;
        logic [31:0] delta;
        logic [31:0] age;
        if (win_size_reg == '0) begin
            w = 1;
        end else if (win_size_reg > WIN_MAX) begin
            w = WIN_MAX;
        end else begin
            w = win_size_reg;
        end
        v.status = ST_OK;
        if (pid == '0) begin
            v.status = ST_ZERO_ID;
        end else begin
            // A lapsed expiry pulls the floor up to the highest id, even if
            // the packet is refused further down.
            age = now - expire_at;
            if (!age[31]) begin
                id_floor = top_id;
            end
            if (epoch < cur_epoch) begin
                v.status = ST_EPOCH_BACK;
            end else begin
                // A newer epoch restarts the window; stale ring bits are
                // hidden behind an extent of zero.
                if (epoch > cur_epoch) begin
                    ring_base = 0;
                    extent    = 0;
                    top_id    = '0;
                    id_floor  = '0;
                    cur_epoch = epoch;
                end
                if (pid > top_id) begin
                    delta = pid - top_id;
                    if (delta < w) begin
                        // Move the base back by delta and clear the skipped ids.
                        ring_base = ((ring_base % w) + w - (delta % w)) % w;
                        seen_map[ring_base] = 1'b1;
                        extent = extent + delta;
                        if (extent > w) begin
                            extent = w;
                        end
                        pos = (ring_base + 1) % w;
                        for (int unsigned k = 1; k < delta; k++) begin
                            seen_map[pos] = 1'b0;
                            pos = (pos + 1) % w;
                        end
                    end else begin
                        ring_base = 0;
                        extent    = w;
                        for (int unsigned k = 0; k < w; k++) begin
                            seen_map[k] = 1'b0;
                        end
                        seen_map[0] = 1'b1;
                    end
                    top_id = pid;
                end else begin
                    delta = top_id - pid;
                    if (delta > backtrack_max) begin
                        backtrack_max = delta;
                    end
                    if (delta >= extent || pid <= id_floor) begin
                        v.status = ST_REPLAY;
                    end else begin
                        pos = ((ring_base % w) + (delta % w)) % w;
                        if (seen_map[pos]) begin
                            v.status = ST_REPLAY;
                        end else begin
                            seen_map[pos] = 1'b1;
                        end
                    end
                end
            end
            if (v.status == ST_OK) begin
                expire_at = now + {1'b0, expire_len_reg};
            end
        end
        v.backtrack = backtrack_max;
        return v;
    endfunction

    always @(posedge i_clk) begin
        verdict_t want;
        if (!i_rst_n) begin
            win_size_reg   = WSIZE_RST;
            expire_len_reg = EXPT_RST;
            foreach (seen_map[i]) begin
                seen_map[i] = 1'b0;
            end
            ring_base     = 0;
            extent        = 0;
            top_id        = '0;
            id_floor      = '0;
            cur_epoch     = '0;
            expire_at     = '0;
            backtrack_max = '0;
            verdict_q.delete();
        end else begin
            // Register writes update our copy; reads must return it.
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr[2] == REG_WINDOW_SIZE) begin
                        win_size_reg = i_pwdata[WSIZE_W-1:0];
                    end else begin
                        expire_len_reg = i_pwdata[EXPT_W-1:0];
                    end
                end else if (i_paddr[2] == REG_WINDOW_SIZE) begin
                    if (i_prdata[WSIZE_W-1:0] !== win_size_reg) begin
                        flag_mismatch("window_size read", win_size_reg,
                                      i_prdata[WSIZE_W-1:0]);
                    end
                end else if (i_prdata[EXPT_W-1:0] !== expire_len_reg) begin
                    flag_mismatch("expire_ticks read", expire_len_reg,
                                  i_prdata[EXPT_W-1:0]);
                end
            end

            // Result beats are checked before new packets are queued.
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 40) begin
                        $display("%0t: result beat with no packet pending, expected none, actual %0h",
                                 $time, i_out_data);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    if (i_out_data[1:0] !== want.status) begin
                        flag_mismatch("status", want.status, i_out_data[1:0]);
                    end
                    if (i_out_data[33:2] !== want.backtrack) begin
                        flag_mismatch("largest_backtrack", want.backtrack, i_out_data[33:2]);
                    end
                    if (i_out_data[39:34] !== '0) begin
                        flag_mismatch("zero fill", '0, i_out_data[39:34]);
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                verdict_q.push_back(judge_packet(i_in_data[31:0], i_in_data[63:32],
                                                 i_in_data[95:64]));
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fail_total;
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

// Drives packet beats and register writes into the replay window check and
// gives the verdict; all prediction and comparison lives in the checker.
module tb;

    localparam int WIN_MAX     = 1024;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;    // packet_id, packet_epoch, now_ticks
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // status, largest_backtrack, zero fill

    int pending;
    int fail_count;

    // Stimulus state: a rough guess of the window, enough to shape sequences.
    logic [31:0] sess_epoch;
    logic [31:0] top_id;
    logic [31:0] last_pid;
    logic [31:0] nowv;
    int          sess_left;
    int unsigned w_eff;
    logic [30:0] cur_expt;
    bit          tx_calm;

    packet_replay_window_check #(
        .WINDOW_MAX(WIN_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    replay_window_checker #(
        .WIN_MAX(WIN_MAX)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls, with calm stretches where it never stalls.
    initial begin
        int hold;
        int cyc;
        bit calm;
        hold = 0;
        cyc  = 0;
        calm = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 400 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) begin
                    hold = pick_idle();
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat or register access.
    always @(posedge i_clk) begin
        int stall_cycles;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            stall_cycles = 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("packet_replay_window_check test failed");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

    // One register write: setup cycle, access cycle, then the bus goes idle.
    task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // One register read; the checker compares the returned value.
    task automatic reg_read(input logic [0:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Presents one packet beat and returns at the edge that takes it.
    task automatic send_packet(input logic [31:0] pid, input logic [31:0] epoch,
                               input logic [31:0] now);
        int gap;
        gap = (!tx_calm && $urandom_range(0, 2) == 0) ? pick_idle() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, epoch, pid};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Holds off the sender until every predicted result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Random packet: mostly in-order traffic and backtracks within one epoch
    // session, with zero ids, stale epochs, repeats and wild ids mixed in.
    task automatic random_packet();
        int unsigned pick;
        logic [31:0] pid;
        logic [31:0] epoch;
        logic [31:0] d;
        epoch = sess_epoch;
        if (sess_left <= 0) begin
            sess_epoch = sess_epoch + $urandom_range(1, 2);
            epoch      = sess_epoch;
            sess_left  = $urandom_range(20, 120);
            pid        = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 2 * w_eff);
            top_id     = pid;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    d = $urandom_range(1, (w_eff < 8) ? w_eff : 8);
                end else if (pick < 95) begin
                    d = $urandom_range(1, w_eff);
                end else begin
                    d = $urandom_range(w_eff, w_eff + 3000);
                end
                pid = top_id + d;
            end else if (pick < 80) begin
                d   = $urandom_range(0, w_eff + 1);
                pid = (d > top_id) ? '0 : top_id - d;
            end else if (pick < 85) begin
                pid   = '0;
                epoch = $urandom;
            end else if (pick < 90) begin
                pid   = top_id - $urandom_range(0, w_eff);
                epoch = $urandom_range(0, sess_epoch - 1);
            end else if (pick < 95) begin
                pid = last_pid;
            end else begin
                pid = $urandom;
            end
            if (pid != '0 && epoch == sess_epoch && pid > top_id) begin
                top_id = pid;
            end
        end
        sess_left--;

        // Ticks mostly creep forward; sometimes they run past the expiry.
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            nowv = nowv + $urandom_range(0, 30);
        end else if (pick < 95) begin
            nowv = nowv + {1'b0, cur_expt} + $urandom_range(0, 10);
        end else begin
            nowv = $urandom;
        end
        last_pid = pid;
        send_packet(pid, epoch, nowv);
    endtask

    // New register setting on an idle block, then a run of random packets.
    task automatic run_phase(input logic [10:0] wsz, input logic [30:0] expt,
                             input int count);
        wait_drained();
        reg_write(prwc_pkg::REG_WINDOW_SIZE, {21'b0, wsz});
        reg_write(prwc_pkg::REG_EXPIRE_TICKS, {1'b0, expt});
        reg_read(prwc_pkg::REG_WINDOW_SIZE);
        reg_read(prwc_pkg::REG_EXPIRE_TICKS);
        if (wsz == '0) begin
            w_eff = 1;
        end else if (wsz > WIN_MAX) begin
            w_eff = WIN_MAX;
        end else begin
            w_eff = wsz;
        end
        cur_expt = expt;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 149) == 0) begin
                wait_drained();
            end
            random_packet();
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        tx_calm       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of the registers.
        reg_read(prwc_pkg::REG_WINDOW_SIZE);
        reg_read(prwc_pkg::REG_EXPIRE_TICKS);

        // Directed packets with the reset setting of 64 bits and 2500 ticks.
        send_packet(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // zero id
        send_packet(32'h0000_0001, 32'h0000_0000, 32'd10);
        send_packet(32'h0000_0001, 32'h0000_0000, 32'd20);         // repeat of highest id
        send_packet(32'h0000_0005, 32'h0000_0000, 32'd30);
        send_packet(32'h0000_0003, 32'h0000_0000, 32'd40);         // backtrack inside window
        send_packet(32'h0000_0003, 32'h0000_0000, 32'd50);         // replay
        send_packet(32'hFFFF_FFFF, 32'h0000_0000, 32'd60);         // jump past the window
        send_packet(32'hFFFF_FFC1, 32'h0000_0000, 32'd70);
        send_packet(32'hFFFF_FFC0, 32'h0000_0000, 32'd80);         // edge of the extent
        send_packet(32'hFFFF_FFBF, 32'h0000_0000, 32'd90);         // just outside it
        send_packet(32'hFFFF_FFF0, 32'h0000_0000, 32'd5000);       // expiry raises floor
        send_packet(32'hFFFF_FFFF, 32'h0000_0000, 32'd5010);
        send_packet(32'h0000_0002, 32'h0000_0005, 32'd5020);       // newer epoch
        send_packet(32'h0000_0009, 32'h0000_0003, 32'd5030);       // older epoch
        send_packet(32'hFFFF_FF00, 32'h0000_0005, 32'hFFFF_FF00);  // expiry wraps ticks
        send_packet(32'hFFFF_FEFF, 32'h0000_0005, 32'h0000_0100);
        send_packet(32'hFFFF_FF01, 32'h0000_0005, 32'h0000_0200);
        send_packet(32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0300);  // huge backtrack
        send_packet(32'hAAAA_AAAA, 32'h8000_0000, 32'h5555_5555);
        send_packet(32'h5555_5555, 32'h8000_0000, 32'h5555_5560);
        send_packet(32'hAAAA_AAAB, 32'h8000_0000, 32'h5555_5570);

        // Random phases over a spread of settings, extremes included.
        sess_epoch = 32'h8000_0000;
        sess_left  = 0;
        top_id     = '0;
        last_pid   = '0;
        nowv       = $urandom;
        run_phase(11'd16, 31'd40, 300);
        run_phase(11'd1, 31'd1, 150);
        run_phase(11'd0, 31'd7, 100);
        run_phase(11'd1024, 31'h7FFF_FFFF, 150);
        run_phase(11'd2047, 31'd300, 80);
        run_phase(11'd37, 31'd1000, 400);
        run_phase(11'd5, 31'd20, 300);
        run_phase(11'd200, 31'd5000, 250);
        run_phase(11'd64, 31'd2500, 250);

        // The last epoch possible ends the run, since nothing can follow it.
        send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_packet(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        wait_drained();
        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("packet_replay_window_check test passed");
        end else begin
            $display("packet_replay_window_check test failed");
        end
        $finish;
    end

endmodule

/* packet_replay_window_check.f */
rtl/core/prwc_pkg.sv
rtl/core/prwc_ram.sv
rtl/core/prwc_mod.sv
rtl/core/prwc_datapath.sv
rtl/core/prwc_ctrl.sv
rtl/core/packet_replay_window_check.sv
test/replay_window_checker.sv
test/tb.sv
